// File: src/itg_pkg.sv
// Shared types, codes and byte helpers for the instruction tunnel generator.
`default_nettype none

package itg_pkg;

  // Bytes carried on the output and in the range registers
  localparam int CAND_BYTES = 15;
  localparam int CAND_W     = 8 * CAND_BYTES;

  // Result status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_VIOL = 2'd1;
  localparam logic [1:0] STATUS_DONE = 2'd2;

  // Marker for "no previous length"
  localparam logic signed [4:0] PREV_NONE = -5'sd1;

  // Legacy and REX prefix bytes
  localparam logic [7:0] PFX_LOCK  = 8'hf0;
  localparam logic [7:0] PFX_REPNE = 8'hf2;
  localparam logic [7:0] PFX_REP   = 8'hf3;
  localparam logic [7:0] PFX_CS    = 8'h2e;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3e;
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_ADSZ  = 8'h67;
  localparam logic [7:0] REX_FIRST = 8'h40;
  localparam logic [7:0] REX_LAST  = 8'h4f;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CFG_SEARCH_MODE      = 4'd0,
    CFG_RANGE_START_HIGH = 4'd1,
    CFG_RANGE_START_LOW  = 4'd2,
    CFG_RANGE_END_HIGH   = 4'd3,
    CFG_RANGE_END_LOW    = 4'd4,
    CFG_START_DEPTH      = 4'd5,
    CFG_MAX_PREFIXES     = 4'd6,
    CFG_ALLOW_REPEATED   = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic       command;
    logic [3:0] observed_length;
  } in_item_t;

  typedef struct packed {
    logic [63:0] candidate_high;
    logic [55:0] candidate_low;
    logic [1:0]  status;
  } out_item_t;

  // Settings the check unit needs
  typedef struct packed {
    logic [63:0] range_end_high;
    logic [55:0] range_end_low;
    logic [3:0]  max_prefixes;
    logic        allow_repeated_prefix;
  } scan_cfg_t;

  // One byte read back from the candidate store
  typedef struct packed {
    logic       clr;
    logic       vld;
    logic [7:0] data;
  } scan_feed_t;

  // Verdict of a finished scan
  typedef struct packed {
    logic viol;
    logic below;
  } scan_res_t;

  function automatic logic is_prefix(input logic [7:0] b);
    return b == PFX_LOCK || b == PFX_REPNE || b == PFX_REP || b == PFX_CS ||
           b == PFX_SS || b == PFX_DS || b == PFX_ES || b == PFX_FS ||
           b == PFX_GS || b == PFX_OPSZ || b == PFX_ADSZ ||
           (b >= REX_FIRST && b <= REX_LAST);
  endfunction

  // Byte idx of a range bound, byte 0 most significant; zero past the last
  function automatic logic [7:0] range_byte(input logic [63:0] hi,
                                            input logic [55:0] lo,
                                            input logic [4:0]  idx);
    logic [CAND_W-1:0] w;
    w = {hi, lo} >> (8 * (CAND_BYTES - 1 - int'(idx)));
    if (int'(idx) < CAND_BYTES) begin
      return w[7:0];
    end
    return 8'h00;
  endfunction

endpackage

`default_nettype wire

// File: src/itg_scan.sv
// Check unit: walks the candidate bytes for prefix rules and the range end.
`default_nettype none

module itg_scan
  import itg_pkg::*;
#(
  parameter int INSN_BYTES = 15,
  localparam int IW = (INSN_BYTES > 1) ? $clog2(INSN_BYTES) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire scan_feed_t               feed_i,
  input  wire logic [IW-1:0]            idx_i,
  input  wire scan_cfg_t                cfg_i,
  output scan_res_t                     res_o,
  output logic [CAND_W-1:0]             cand_o
);

  localparam int CNTW = $clog2(INSN_BYTES + 1);
  localparam int PADB = (INSN_BYTES > CAND_BYTES) ? INSN_BYTES : CAND_BYTES;

  logic [7:0]      bytes_q [INSN_BYTES];
  logic [7:0]      pad     [PADB];
  logic [CNTW-1:0] cnt_q;
  logic            run_q, rep_q, dec_q, lt_q;
  logic [7:0]      end_b;
  logic            match;

  // End bound byte at the same position
  assign end_b = range_byte(cfg_i.range_end_high, cfg_i.range_end_low, 5'(idx_i));

  // Does this byte repeat an earlier one (all earlier ones are prefixes here)
  always_comb begin
    match = 1'b0;
    for (int j = 0; j < INSN_BYTES; j++) begin
      if (int'(idx_i) > j && bytes_q[j] == feed_i.data) begin
        match = 1'b1;
      end
    end
  end

  // Prefix run and lexicographic compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b1;
      cnt_q <= '0;
      rep_q <= 1'b0;
      dec_q <= 1'b0;
      lt_q  <= 1'b0;
    end else if (feed_i.clr) begin
      run_q <= 1'b1;
      cnt_q <= '0;
      rep_q <= 1'b0;
      dec_q <= 1'b0;
      lt_q  <= 1'b0;
    end else if (feed_i.vld) begin
      if (run_q) begin
        if (is_prefix(feed_i.data)) begin
          cnt_q <= cnt_q + 1'b1;
          if (match) begin
            rep_q <= 1'b1;
          end
        end else begin
          run_q <= 1'b0;
        end
      end
      if (!dec_q && feed_i.data != end_b) begin
        dec_q <= 1'b1;
        lt_q  <= feed_i.data < end_b;
      end
    end
  end

  // Copy of the candidate for the output word
  always_ff @(posedge clk_i) begin
    if (feed_i.vld) begin
      bytes_q[idx_i] <= feed_i.data;
    end
  end

  always_comb begin
    for (int p = 0; p < PADB; p++) begin
      pad[p] = 8'h00;
    end
    for (int j = 0; j < INSN_BYTES; j++) begin
      pad[j] = bytes_q[j];
    end
    for (int i = 0; i < CAND_BYTES; i++) begin
      cand_o[CAND_W-1-8*i -: 8] = pad[i];
    end
  end

  assign res_o.viol  = (cnt_q > cfg_i.max_prefixes) ||
                       (!cfg_i.allow_repeated_prefix && rep_q);
  assign res_o.below = dec_q && lt_q;

endmodule

`default_nettype wire

// File: src/instruction_tunnel_generator_top.sv
// Top level: candidate generator with its byte store, sequencer and config registers.
// Usage:
//   Config writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always taken
//   (cfg_ready_o high) and must only happen while the block is idle.
//   An input item (command, observed_length) is taken when in_valid_i is high
//   and in_stall_o low; in_stall_o is low only while the sequencer is idle.
//   Each item yields one result item (candidate bytes and status).
// Sequence, N = INSN_BYTES:
//   start item:  load the N bytes of the range start, scan all N bytes,
//                then post the result.
//   next item:   carry chain over K bytes (K bytes touched, 0 if nothing is
//                incremented), then scan and post as above.
//   The candidate store has one write and one read port, so every byte
//   takes one memory access per cycle.
// Reset empties the output register and drops any active range, so the
// first item always loads the range start. No clearing pass is needed.
// When the receiver stalls, the finished result holds in the output
// register; the next item can be taken and worked on meanwhile, and its
// result waits in the post cycle until the register frees up.
`default_nettype none

module instruction_tunnel_generator_top
  import itg_pkg::*;
#(
  parameter int INSN_BYTES = 15
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);

  localparam int IW = (INSN_BYTES > 1) ? $clog2(INSN_BYTES) : 1;
  localparam int CW = $clog2(INSN_BYTES) + 1;
  localparam int DW = $clog2(INSN_BYTES + 1);
  localparam int SW = $clog2(INSN_BYTES + 1);
  localparam logic signed [6:0] NB7 = 7'(INSN_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CARRY_RD,
    ST_CARRY_WR,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Configuration registers
  logic        mode_q;
  logic [63:0] start_hi_q, end_hi_q;
  logic [55:0] start_lo_q, end_lo_q;
  logic [3:0]  depth_cfg_q, maxp_q;
  logic        allow_q;

  // Sequencer state
  state_e               state_q, state_d;
  logic signed [CW-1:0] cursor_q, cursor_d;
  logic signed [4:0]    prev_q, prev_d;
  logic [SW-1:0]        cnt_q, cnt_d;
  logic                 active_q, active_d;
  out_item_t            out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IW-1:0]        rd_idx_q, rd_idx_d;

  // Candidate byte store
  logic [7:0]    mem_q [INSN_BYTES];
  logic [7:0]    rd_data_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  logic [DW-1:0]     depth;
  logic signed [6:0] cur7, obs7, prev7, dep7, bstart7, tstart7, tnext7;
  logic              deepen;
  logic [7:0]        inc;
  logic              out_load;
  logic              scan_clr;

  scan_feed_t        feed;
  scan_cfg_t         scfg;
  scan_res_t         sres;
  logic [CAND_W-1:0] cand;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b1;
      start_hi_q  <= '0;
      start_lo_q  <= '0;
      end_hi_q    <= '1;
      end_lo_q    <= '1;
      depth_cfg_q <= 4'd1;
      maxp_q      <= 4'd4;
      allow_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SEARCH_MODE:      mode_q      <= cfg_data_i[0];
        CFG_RANGE_START_HIGH: start_hi_q  <= cfg_data_i;
        CFG_RANGE_START_LOW:  start_lo_q  <= cfg_data_i[55:0];
        CFG_RANGE_END_HIGH:   end_hi_q    <= cfg_data_i;
        CFG_RANGE_END_LOW:    end_lo_q    <= cfg_data_i[55:0];
        CFG_START_DEPTH:      depth_cfg_q <= cfg_data_i[3:0];
        CFG_MAX_PREFIXES:     maxp_q      <= cfg_data_i[3:0];
        CFG_ALLOW_REPEATED:   allow_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Depth saturated to the store size, cursor arithmetic in 7-bit signed
  always_comb begin
    if (32'(depth_cfg_q) > INSN_BYTES) begin
      depth = DW'(INSN_BYTES);
    end else begin
      depth = DW'(depth_cfg_q);
    end
    dep7    = $signed(7'(depth));
    bstart7 = dep7 - 7'sd1;
    tstart7 = (dep7 > NB7 - 7'sd1) ? NB7 - 7'sd1 : dep7;
    cur7    = 7'(cursor_q);
    obs7    = $signed(7'(in_data_i.observed_length));
    prev7   = 7'(prev_q);
    deepen  = (obs7 != prev7) && (cur7 < obs7 - 7'sd1) && (cur7 + 7'sd1 < NB7);
    tnext7  = deepen ? cur7 + 7'sd1 : cur7;
  end

  assign inc      = rd_data_q + 8'd1;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_vld_d    = 1'b0;
    rd_idx_d    = '0;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_ra      = '0;
    scan_clr    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          if (!in_data_i.command || !active_q) begin
            prev_d   = PREV_NONE;
            cursor_d = mode_q ? CW'(tstart7) : CW'(bstart7);
            state_d  = ST_LOAD;
          end else if (!mode_q) begin
            cursor_d = CW'(bstart7);
            state_d  = bstart7[6] ? ST_SCAN : ST_CARRY_RD;
          end else begin
            cursor_d = CW'(tnext7);
            prev_d   = $signed(5'(in_data_i.observed_length));
            state_d  = tnext7[6] ? ST_SCAN : ST_CARRY_RD;
          end
        end
      end
      ST_LOAD: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[IW-1:0];
        mem_wd = range_byte(start_hi_q, start_lo_q, 5'(cnt_q));
        if (cnt_q == SW'(INSN_BYTES - 1)) begin
          cnt_d   = '0;
          state_d = ST_SCAN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_CARRY_RD: begin
        mem_ra  = cursor_q[IW-1:0];
        state_d = ST_CARRY_WR;
      end
      ST_CARRY_WR: begin
        // increment at the cursor; on wrap move left and read that byte
        mem_we = 1'b1;
        mem_wa = cursor_q[IW-1:0];
        mem_wd = inc;
        if (inc == 8'd0) begin
          cursor_d = cursor_q - CW'(1);
          if (mode_q) begin
            prev_d = PREV_NONE;
          end
          if (cursor_q == '0) begin
            state_d = ST_SCAN;
          end else begin
            mem_ra = cursor_q[IW-1:0] - 1'b1;
          end
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_clr = cnt_q == '0;
        if (cnt_q < SW'(INSN_BYTES)) begin
          mem_ra   = cnt_q[IW-1:0];
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[IW-1:0];
          cnt_d    = cnt_q + 1'b1;
        end else begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_d.candidate_high = cand[CAND_W-1 -: 64];
          out_d.candidate_low  = cand[55:0];
          if (sres.viol) begin
            out_d.status = STATUS_VIOL;
          end else if (!sres.below || cursor_q[CW-1]) begin
            out_d.status = STATUS_DONE;
          end else begin
            out_d.status = STATUS_OK;
          end
          out_valid_d = 1'b1;
          active_d    = !sres.viol;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cursor_q    <= '1;
      prev_q      <= PREV_NONE;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Candidate store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[mem_ra];
  end

  // Check unit
  assign feed.clr  = scan_clr;
  assign feed.vld  = rd_vld_q;
  assign feed.data = rd_data_q;

  assign scfg.range_end_high        = end_hi_q;
  assign scfg.range_end_low         = end_lo_q;
  assign scfg.max_prefixes          = maxp_q;
  assign scfg.allow_repeated_prefix = allow_q;

  itg_scan #(
    .INSN_BYTES(INSN_BYTES)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .feed_i (feed),
    .idx_i  (rd_idx_q),
    .cfg_i  (scfg),
    .res_o  (sres),
    .cand_o (cand)
  );

  // An accepted item always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q != ST_IDLE)
    else $error("item accepted but sequencer stayed idle");

  // Posting a result shows it on the output next cycle
  a_post_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("posted result not visible");

  // A prefix violation drops the range
  a_viol_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.status == STATUS_VIOL) |=> !active_q)
    else $error("range still active after prefix violation");

  // Carry chain never reads the entry it writes in the same cycle
  a_carry_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CARRY_WR && inc == 8'd0 && cursor_q != '0) |-> mem_ra != mem_wa)
    else $error("carry read collides with write");

endmodule

`default_nettype wire

// File: sim/instruction_tunnel_generator_top_tb.sv
// Self-checking testbench for the instruction tunnel generator: directed and random commands.
`timescale 1ns / 1ps

module instruction_tunnel_generator_top_tb;
  import itg_pkg::*;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_NEXT    = 1'b1;
  localparam logic MODE_BRUTE  = 1'b0;
  localparam logic MODE_TUNNEL = 1'b1;

  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;

  // One full register set
  typedef struct {
    logic        mode;
    logic [63:0] start_hi;
    logic [55:0] start_lo;
    logic [63:0] end_hi;
    logic [55:0] end_lo;
    logic [3:0]  depth;
    logic [3:0]  max_pfx;
    logic        allow_rep;
  } search_cfg_t;

  // Shadow of the generator: predicts each candidate and checks the results
  class candidate_scoreboard;
    logic        search_mode;
    logic [63:0] start_hi, end_hi;
    logic [55:0] start_lo, end_lo;
    logic [3:0]  start_depth, max_prefixes;
    logic        allow_repeated;
    logic [7:0]  cand [CAND_BYTES];
    int          cursor;
    int          prev_len;
    bit          range_active;
    out_item_t   expected_cands [$];
    int          errors;

    function new();
      search_mode    = MODE_TUNNEL;
      start_hi       = '0;
      start_lo       = '0;
      end_hi         = '1;
      end_lo         = '1;
      start_depth    = 4'd1;
      max_prefixes   = 4'd4;
      allow_repeated = 1'b0;
      foreach (cand[i]) cand[i] = 8'h00;
      cursor         = -1;
      prev_len       = -1;
      range_active   = 1'b0;
      errors         = 0;
    endfunction

    function void write_cfg(cfg_idx_e idx, logic [63:0] v);
      case (idx)
        CFG_SEARCH_MODE:      search_mode = v[0];
        CFG_RANGE_START_HIGH: start_hi = v;
        CFG_RANGE_START_LOW:  start_lo = v[55:0];
        CFG_RANGE_END_HIGH:   end_hi = v;
        CFG_RANGE_END_LOW:    end_lo = v[55:0];
        CFG_START_DEPTH:      start_depth = v[3:0];
        CFG_MAX_PREFIXES:     max_prefixes = v[3:0];
        CFG_ALLOW_REPEATED:   allow_repeated = v[0];
        default: ;
      endcase
    endfunction

    // Byte i of a range bound, byte 0 most significant
    function logic [7:0] bound_byte(logic [63:0] hi, logic [55:0] lo, int i);
      if (i < 8) return hi[63 - 8 * i -: 8];
      if (i < 15) return lo[55 - 8 * (i - 8) -: 8];
      return 8'h00;
    endfunction

    function bit is_pfx(logic [7:0] b);
      case (b)
        PFX_LOCK, PFX_REPNE, PFX_REP, PFX_CS, PFX_SS, PFX_DS, PFX_ES,
        PFX_FS, PFX_GS, PFX_OPSZ, PFX_ADSZ: return 1'b1;
        default: return b >= REX_FIRST && b <= REX_LAST;
      endcase
    endfunction

    function bit has_repeat(int n);
      bit seen [256];
      int i;
      for (i = 0; i < n; i++) begin
        if (seen[cand[i]]) return 1'b1;
        seen[cand[i]] = 1'b1;
      end
      return 1'b0;
    endfunction

    function bit below_end();
      logic [7:0] e;
      int i;
      for (i = 0; i < CAND_BYTES; i++) begin
        e = bound_byte(end_hi, end_lo, i);
        if (cand[i] != e) return cand[i] < e;
      end
      return 1'b0;
    endfunction

    // Advance the candidate for one command and form its result
    function out_item_t step_candidate(in_item_t it);
      bit        restart;
      int        obs, depth, npfx, i;
      out_item_t res;
      restart = (it.command == CMD_START) || !range_active;
      obs     = int'(it.observed_length);
      depth   = int'(start_depth);
      if (depth > CAND_BYTES) depth = CAND_BYTES;

      if (restart) begin
        for (i = 0; i < CAND_BYTES; i++) cand[i] = bound_byte(start_hi, start_lo, i);
        prev_len = -1;
        if (search_mode == MODE_BRUTE) cursor = depth - 1;
        else cursor = (depth > CAND_BYTES - 1) ? CAND_BYTES - 1 : depth;
      end else if (search_mode == MODE_BRUTE) begin
        // big-endian count over the first depth bytes
        for (cursor = depth - 1; cursor >= 0; cursor--) begin
          cand[cursor] += 8'd1;
          if (cand[cursor] != 8'd0) break;
        end
      end else begin
        // deepen on a length change, then increment with carry to the left
        if (obs != prev_len && cursor < obs - 1 && cursor + 1 < CAND_BYTES) cursor++;
        prev_len = obs;
        if (cursor >= 0) begin
          cand[cursor] += 8'd1;
          while (cursor >= 0 && cand[cursor] == 8'd0) begin
            cursor--;
            if (cursor >= 0) cand[cursor] += 8'd1;
            prev_len = -1;
          end
        end
      end
      range_active = 1'b1;

      npfx = 0;
      while (npfx < CAND_BYTES && is_pfx(cand[npfx])) npfx++;
      if (npfx > int'(max_prefixes) || (!allow_repeated && has_repeat(npfx))) begin
        res.status   = STATUS_VIOL;
        range_active = 1'b0;
      end else if (!below_end() || cursor < 0) begin
        res.status = STATUS_DONE;
      end else begin
        res.status = STATUS_OK;
      end
      for (i = 0; i < 8; i++) res.candidate_high[63 - 8 * i -: 8] = cand[i];
      for (i = 8; i < CAND_BYTES; i++) res.candidate_low[55 - 8 * (i - 8) -: 8] = cand[i];
      return res;
    endfunction

    function void note_command(in_item_t it);
      expected_cands.push_back(step_candidate(it));
    endfunction

    function void check_candidate(out_item_t got);
      out_item_t exp_c;
      if (expected_cands.size() == 0) begin
        $error("unexpected result: high %h low %h status %0d",
               got.candidate_high, got.candidate_low, got.status);
        errors++;
        return;
      end
      exp_c = expected_cands.pop_front();
      if (got.candidate_high !== exp_c.candidate_high) begin
        $error("candidate_high: expected %h, actual %h", exp_c.candidate_high,
               got.candidate_high);
        errors++;
      end
      if (got.candidate_low !== exp_c.candidate_low) begin
        $error("candidate_low: expected %h, actual %h", exp_c.candidate_low,
               got.candidate_low);
        errors++;
      end
      if (got.status !== exp_c.status) begin
        $error("status: expected %0d, actual %0d", exp_c.status, got.status);
        errors++;
      end
    endfunction

    function int pending();
      return expected_cands.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;

  candidate_scoreboard cand_sb = new();

  bit src_calm      = 1'b0;
  bit sink_calm     = 1'b0;
  bit long_hold_req = 1'b0;

  instruction_tunnel_generator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic in_item_t cmd_item(logic cmd, logic [3:0] obs);
    in_item_t it;
    it.command         = cmd;
    it.observed_length = obs;
    return it;
  endfunction

  function automatic search_cfg_t reset_cfg();
    search_cfg_t c;
    c.mode      = MODE_TUNNEL;
    c.start_hi  = '0;
    c.start_lo  = '0;
    c.end_hi    = '1;
    c.end_lo    = '1;
    c.depth     = 4'd1;
    c.max_pfx   = 4'd4;
    c.allow_rep = 1'b0;
    return c;
  endfunction

  function automatic logic [7:0] pick_prefix();
    case ($urandom_range(0, 11))
      0:  return PFX_LOCK;
      1:  return PFX_REPNE;
      2:  return PFX_REP;
      3:  return PFX_CS;
      4:  return PFX_SS;
      5:  return PFX_DS;
      6:  return PFX_ES;
      7:  return PFX_FS;
      8:  return PFX_GS;
      9:  return PFX_OPSZ;
      10: return PFX_ADSZ;
      default: return REX_FIRST + 8'($urandom_range(0, 15));
    endcase
  endfunction

  // Bytes biased toward carry and prefix boundaries
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1: return 8'h00;
      2, 3: return 8'hff;
      4:    return pick_prefix();
      5:    return 8'hfe;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic search_cfg_t rand_cfg();
    search_cfg_t c;
    logic [7:0]  sb [CAND_BYTES];
    logic [7:0]  eb [CAND_BYTES];
    int          j, k, npfx;
    for (j = 0; j < CAND_BYTES; j++) sb[j] = pick_byte();
    if ($urandom_range(0, 4) == 0) begin
      npfx = $urandom_range(1, CAND_BYTES);
      for (j = 0; j < npfx; j++) sb[j] = pick_prefix();
    end
    c.mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       c.depth = 4'd0;
      1:       c.depth = 4'd15;
      2:       c.depth = 4'd14;
      default: c.depth = 4'($urandom_range(1, 4));
    endcase
    c.max_pfx   = 4'($urandom_range(0, 15));
    c.allow_rep = 1'($urandom_range(0, 1));
    // range end: empty, open, random, or just past the start
    case ($urandom_range(0, 9))
      0:       foreach (eb[j]) eb[j] = 8'h00;
      1, 2, 3: foreach (eb[j]) eb[j] = 8'hff;
      4:       foreach (eb[j]) eb[j] = 8'($urandom);
      default: begin
        k = $urandom_range(0, (c.depth > 14) ? 14 : int'(c.depth));
        foreach (eb[j]) eb[j] = (j < k) ? sb[j] : 8'($urandom);
        eb[k] = (sb[k] > 8'hfc) ? 8'hff : sb[k] + 8'($urandom_range(1, 3));
      end
    endcase
    for (j = 0; j < 8; j++) begin
      c.start_hi[63 - 8 * j -: 8] = sb[j];
      c.end_hi[63 - 8 * j -: 8]   = eb[j];
    end
    for (j = 8; j < CAND_BYTES; j++) begin
      c.start_lo[55 - 8 * (j - 8) -: 8] = sb[j];
      c.end_lo[55 - 8 * (j - 8) -: 8]   = eb[j];
    end
    return c;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [63:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cand_sb.write_cfg(idx, v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_cfg(search_cfg_t c);
    write_reg(CFG_SEARCH_MODE, 64'(c.mode));
    write_reg(CFG_RANGE_START_HIGH, c.start_hi);
    write_reg(CFG_RANGE_START_LOW, 64'(c.start_lo));
    write_reg(CFG_RANGE_END_HIGH, c.end_hi);
    write_reg(CFG_RANGE_END_LOW, 64'(c.end_lo));
    write_reg(CFG_START_DEPTH, 64'(c.depth));
    write_reg(CFG_MAX_PREFIXES, 64'(c.max_pfx));
    write_reg(CFG_ALLOW_REPEATED, 64'(c.allow_rep));
  endtask

  // Offer one command after a random gap; return once it is taken
  task automatic send_item(in_item_t it);
    int gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    cand_sb.note_command(it);
  endtask

  // Wait until every candidate is back and the block has settled
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cand_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(search_cfg_t c, in_item_t items [$]);
    apply_cfg(c);
    foreach (items[i]) send_item(items[i]);
    drain();
  endtask

  // Result side: random stalls, optional long hold-off
  initial begin : result_sink
    int hold;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        cand_sb.check_candidate(out_data_o);
        hold = draw_gap(sink_calm);
      end
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("instruction_tunnel_generator_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    search_cfg_t c;
    in_item_t    items [$];
    in_item_t    it;
    logic [3:0]  last_obs;
    int          sent, phase, n, k;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SEARCH_MODE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: next with no active range acts as a start, tunnel deepens
    items = '{cmd_item(CMD_NEXT, 4'd0), cmd_item(CMD_NEXT, 4'd15),
              cmd_item(CMD_NEXT, 4'd15), cmd_item(CMD_NEXT, 4'd3),
              cmd_item(CMD_START, 4'd15)};
    foreach (items[i]) send_item(items[i]);
    drain();

    // Brute with zero depth: nothing counted, finished at once
    c       = reset_cfg();
    c.mode  = MODE_BRUTE;
    c.depth = 4'd0;
    run_phase(c, '{cmd_item(CMD_START, 4'd0), cmd_item(CMD_NEXT, 4'd9)});

    // Brute with full depth, start all ones: equals the end, then wraps
    c.depth    = 4'd15;
    c.start_hi = '1;
    c.start_lo = '1;
    run_phase(c, '{cmd_item(CMD_START, 4'd1), cmd_item(CMD_NEXT, 4'd2),
                   cmd_item(CMD_NEXT, 4'd4)});

    // Repeated prefix drops the range, the next restarts it
    c          = reset_cfg();
    c.start_hi = {8{PFX_OPSZ}};
    c.start_lo = {7{PFX_OPSZ}};
    run_phase(c, '{cmd_item(CMD_START, 4'd5), cmd_item(CMD_NEXT, 4'd5)});

    // All bytes prefixes, repeats allowed and the limit at its top
    c.allow_rep = 1'b1;
    c.max_pfx   = 4'd15;
    run_phase(c, '{cmd_item(CMD_START, 4'd8), cmd_item(CMD_NEXT, 4'd15)});

    // Same string one prefix over the limit
    c.max_pfx = 4'd14;
    run_phase(c, '{cmd_item(CMD_START, 4'd6)});

    // Tunnel cursor pinned at the last byte, carry into the byte before
    c          = reset_cfg();
    c.depth    = 4'd15;
    c.start_lo = 56'hff;
    run_phase(c, '{cmd_item(CMD_START, 4'd15), cmd_item(CMD_NEXT, 4'd15),
                   cmd_item(CMD_NEXT, 4'd15)});

    // Tunnel carry out of byte 0 leaves the cursor before the string
    c          = reset_cfg();
    c.depth    = 4'd0;
    c.start_hi = 64'hff00_0000_0000_0000;
    run_phase(c, '{cmd_item(CMD_START, 4'd0), cmd_item(CMD_NEXT, 4'd0),
                   cmd_item(CMD_NEXT, 4'd0), cmd_item(CMD_NEXT, 4'd5)});

    // Empty range
    c        = reset_cfg();
    c.end_hi = '0;
    c.end_lo = '0;
    run_phase(c, '{cmd_item(CMD_START, 4'd10), cmd_item(CMD_NEXT, 4'd7)});

    // No prefixes allowed at all
    c          = reset_cfg();
    c.max_pfx  = 4'd0;
    c.start_hi = {REX_FIRST, 56'h0};
    run_phase(c, '{cmd_item(CMD_START, 4'd12)});

    // Random phases: mostly next commands running through a fresh range
    sent     = 0;
    phase    = 0;
    last_obs = 4'd0;
    while (sent < RANDOM_ITEMS) begin
      c = rand_cfg();
      apply_cfg(c);
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      if (phase == 2 || phase == 9) begin
        // fill the block while results are held back
        src_calm      = 1'b1;
        long_hold_req = 1'b1;
      end
      n = $urandom_range(20, 120);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) >= 6) last_obs = 4'($urandom_range(0, 15));
        it = cmd_item(($urandom_range(0, 11) == 0) ? CMD_START : CMD_NEXT, last_obs);
        send_item(it);
      end
      sent += n;
      phase++;
      drain();
    end

    if (cand_sb.errors == 0 && cand_sb.pending() == 0) begin
      $display("instruction_tunnel_generator_top regression: pass");
    end else begin
      $display("instruction_tunnel_generator_top regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/itg_pkg.sv
src/itg_scan.sv
src/instruction_tunnel_generator_top.sv
sim/instruction_tunnel_generator_top_tb.sv
